>>> rtl/gwwlb_pkg.sv
package gwwlb_pkg;

  // Run widths of the line, whitespace and word accumulators
  localparam int COUNT_BITS = 16;
  localparam int WIDTH_BITS = 16;

  localparam logic [15:0] CODE_NEWLINE = 16'd10;
  localparam logic [15:0] CODE_SPACE   = 16'd32;
  localparam logic [15:0] CODE_TAB     = 16'd9;

  typedef logic [COUNT_BITS-1:0]        count_t;
  typedef logic signed [WIDTH_BITS-1:0] wid_t;

  localparam wid_t WID_MAX = {1'b0, {(WIDTH_BITS-1){1'b1}}};
  localparam wid_t WID_MIN = {1'b1, {(WIDTH_BITS-1){1'b0}}};

  // Register map, indexed by word address
  typedef enum logic {
    REG_MAX_LINE_WIDTH = 1'b0,
    REG_CHAR_SPACING   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [14:0]       max_line_width;
    logic signed [7:0] char_spacing;
  } cfg_t;

  typedef struct packed {
    logic [15:0] char_code;
    logic        glyph_present;
    logic [7:0]  glyph_advance;
    logic        end_of_text;
  } char_t;

  typedef struct packed {
    logic               is_line;
    logic [15:0]        line_char_count;
    logic signed [15:0] line_pixel_width;
    logic               final_result;
  } res_t;

  // Results of one character, handed from the core to the output queue
  typedef struct packed {
    logic fire;
    logic first_valid;
    logic second_valid;
    res_t first;
    res_t second;
  } push_t;

  function automatic count_t sat_cnt_add(count_t a, count_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  function automatic wid_t sat_wid_add(wid_t a, wid_t b);
    logic signed [WIDTH_BITS:0] s;
    s = (WIDTH_BITS+1)'(a) + (WIDTH_BITS+1)'(b);
    if (s[WIDTH_BITS] != s[WIDTH_BITS-1]) begin
      return s[WIDTH_BITS] ? WID_MIN : WID_MAX;
    end
    return s[WIDTH_BITS-1:0];
  endfunction

  function automatic logic [15:0] out_count(count_t c);
    logic [32:0] cx;
    cx = 33'(c);
    return (cx > 33'h0FFFF) ? 16'hFFFF : cx[15:0];
  endfunction

  function automatic logic signed [15:0] out_width(wid_t w);
    logic signed [32:0] wx;
    wx = 33'(w);
    if (wx > 33'sd32767) begin
      return 16'sh7FFF;
    end else if (wx < -33'sd32768) begin
      return 16'sh8000;
    end
    return wx[15:0];
  endfunction

endpackage

>>> rtl/gwwlb_text_if.sv
interface gwwlb_text_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        glyph_present;
  logic [7:0]  glyph_advance;
  logic        end_of_text;

  modport source (
    output valid, char_code, glyph_present, glyph_advance, end_of_text,
    input  ready
  );
  modport sink (
    input  valid, char_code, glyph_present, glyph_advance, end_of_text,
    output ready
  );
endinterface

>>> rtl/gwwlb_line_if.sv
interface gwwlb_line_if;
  logic               valid;
  logic               ready;
  logic               is_line;
  logic [15:0]        line_char_count;
  logic signed [15:0] line_pixel_width;
  logic               final_result;

  modport source (
    output valid, is_line, line_char_count, line_pixel_width, final_result,
    input  ready
  );
  modport sink (
    input  valid, is_line, line_char_count, line_pixel_width, final_result,
    output ready
  );
endinterface

>>> rtl/gwwlb_cfg.sv
module gwwlb_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output gwwlb_pkg::cfg_t    cfg
);

  gwwlb_pkg::reg_idx_t idx;
  logic                wr;

  assign pready = 1'b1;
  assign idx    = gwwlb_pkg::reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_line_width <= 15'd320;
      cfg.char_spacing   <= 8'sd0;
    end else if (wr) begin
      unique case (idx)
        gwwlb_pkg::REG_MAX_LINE_WIDTH: cfg.max_line_width <= pwdata[14:0];
        gwwlb_pkg::REG_CHAR_SPACING:   cfg.char_spacing   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gwwlb_pkg::REG_MAX_LINE_WIDTH: prdata = {17'd0, cfg.max_line_width};
      gwwlb_pkg::REG_CHAR_SPACING:   prdata = {24'd0, cfg.char_spacing};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/gwwlb_core.sv
module gwwlb_core (
  input  logic               clk,
  input  logic               rst,
  input  gwwlb_pkg::cfg_t    cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  gwwlb_pkg::char_t   in_item,
  input  logic               slot_free,
  output gwwlb_pkg::push_t   push
);

  localparam int WB       = gwwlb_pkg::WIDTH_BITS;
  localparam int SUM_BITS = (WB + 3 > 17) ? WB + 3 : 17;

  // input register
  logic              item_v;
  gwwlb_pkg::char_t  item;
  logic              fire;

  // runs
  gwwlb_pkg::count_t line_chars, space_chars, word_chars;
  gwwlb_pkg::wid_t   line_width, space_width, word_width;

  gwwlb_pkg::count_t l1c, s1c, w1c, bsc, bwc, e0c, jc, flc;
  gwwlb_pkg::wid_t   l1w, s1w, w1w, bsw, bww, e0w, jw, flw;
  gwwlb_pkg::wid_t   adv_w;
  logic signed [9:0]          adv_sp;
  logic signed [SUM_BITS-1:0] sum;
  logic is_nl, is_ws, is_word, ovf, e0, e1, last;

  assign fire     = item_v && slot_free;
  assign in_ready = !item_v || slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_v <= 1'b1;
    end else if (fire) begin
      item_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  always_comb begin
    is_nl   = item.char_code == gwwlb_pkg::CODE_NEWLINE;
    is_ws   = item.glyph_present && !is_nl &&
              (item.char_code == gwwlb_pkg::CODE_SPACE ||
               item.char_code == gwwlb_pkg::CODE_TAB);
    is_word = item.glyph_present && !is_nl && !is_ws;
    last    = item.end_of_text;

    adv_sp = $signed({2'b00, item.glyph_advance}) + 10'(cfg.char_spacing);
    adv_w  = WB'(adv_sp);

    // overflow test uses the bare advance
    sum = SUM_BITS'(line_width) + SUM_BITS'(space_width) + SUM_BITS'(word_width)
        + SUM_BITS'($signed({1'b0, item.glyph_advance}));
    ovf = sum > SUM_BITS'($signed({1'b0, cfg.max_line_width}));

    // whole pending run joined into the line
    jc = gwwlb_pkg::sat_cnt_add(gwwlb_pkg::sat_cnt_add(line_chars, space_chars),
                                word_chars);
    jw = gwwlb_pkg::sat_wid_add(gwwlb_pkg::sat_wid_add(line_width, space_width),
                                word_width);

    l1c = line_chars;  l1w = line_width;
    s1c = space_chars; s1w = space_width;
    w1c = word_chars;  w1w = word_width;
    bsc = space_chars; bsw = space_width;
    bwc = word_chars;  bww = word_width;
    e0  = 1'b0;
    e0c = line_chars;  e0w = line_width;

    if (is_nl) begin
      e0 = 1'b1;
      if (word_chars != '0) begin
        e0c = jc;
        e0w = jw;
      end
      l1c = '0; l1w = '0; s1c = '0; s1w = '0; w1c = '0; w1w = '0;
    end else if (is_ws) begin
      if (word_chars != '0) begin
        l1c = jc; l1w = jw;
        w1c = '0; w1w = '0;
        bsc = '0; bsw = '0;
      end
      s1c = gwwlb_pkg::sat_cnt_add(bsc, gwwlb_pkg::count_t'(1));
      s1w = gwwlb_pkg::sat_wid_add(bsw, adv_w);
    end else if (is_word) begin
      if (ovf) begin
        e0 = 1'b1;
        l1c = '0; l1w = '0; s1c = '0; s1w = '0;
        if (line_chars == '0) begin
          // empty line: split the word here
          e0c = jc; e0w = jw;
          bwc = '0; bww = '0;
        end
      end
      w1c = gwwlb_pkg::sat_cnt_add(bwc, gwwlb_pkg::count_t'(1));
      w1w = gwwlb_pkg::sat_wid_add(bww, adv_w);
    end

    // end-of-text flush
    if (w1c != '0) begin
      flc = gwwlb_pkg::sat_cnt_add(gwwlb_pkg::sat_cnt_add(l1c, s1c), w1c);
      flw = gwwlb_pkg::sat_wid_add(gwwlb_pkg::sat_wid_add(l1w, s1w), w1w);
    end else begin
      flc = l1c;
      flw = l1w;
    end
    e1 = last && (flc != '0);

    push.fire         = fire;
    push.first_valid  = e0 || last;
    push.second_valid = e0 && e1;

    push.second.is_line          = 1'b1;
    push.second.line_char_count  = gwwlb_pkg::out_count(flc);
    push.second.line_pixel_width = gwwlb_pkg::out_width(flw);
    push.second.final_result     = last;

    if (e0) begin
      push.first.is_line          = 1'b1;
      push.first.line_char_count  = gwwlb_pkg::out_count(e0c);
      push.first.line_pixel_width = gwwlb_pkg::out_width(e0w);
    end else if (e1) begin
      push.first.is_line          = 1'b1;
      push.first.line_char_count  = gwwlb_pkg::out_count(flc);
      push.first.line_pixel_width = gwwlb_pkg::out_width(flw);
    end else begin
      // terminator
      push.first.is_line          = 1'b0;
      push.first.line_char_count  = 16'd0;
      push.first.line_pixel_width = 16'sd0;
    end
    push.first.final_result = last && !(e0 && e1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_chars  <= '0; line_width  <= '0;
      space_chars <= '0; space_width <= '0;
      word_chars  <= '0; word_width  <= '0;
    end else if (fire) begin
      if (last) begin
        line_chars  <= '0; line_width  <= '0;
        space_chars <= '0; space_width <= '0;
        word_chars  <= '0; word_width  <= '0;
      end else begin
        line_chars  <= l1c; line_width  <= l1w;
        space_chars <= s1c; space_width <= s1w;
        word_chars  <= w1c; word_width  <= w1w;
      end
    end
  end

endmodule

>>> rtl/gwwlb_outq.sv
module gwwlb_outq (
  input  logic               clk,
  input  logic               rst,
  input  gwwlb_pkg::push_t   push,
  output logic               slot_free,
  output logic               out_valid,
  input  logic               out_ready,
  output gwwlb_pkg::res_t    out_res
);

  logic            v0, v1;
  gwwlb_pkg::res_t d0, d1;
  logic            pop;

  assign pop       = v0 && out_ready;
  // both slots empty once the head beat leaves
  assign slot_free = !v1 && (!v0 || out_ready);
  assign out_valid = v0;
  assign out_res   = d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (push.fire) begin
      v0 <= push.first_valid;
      v1 <= push.second_valid;
    end else if (pop) begin
      v0 <= v1;
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.fire) begin
      d0 <= push.first;
      d1 <= push.second;
    end else if (pop) begin
      d0 <= d1;
    end
  end

  a_tail_needs_head: assert property (@(posedge clk) disable iff (rst) v1 |-> v0)
    else $error("second slot held without head");
  a_push_into_empty: assert property (@(posedge clk) disable iff (rst)
    push.fire |-> (!v1 && (!v0 || out_ready)))
    else $error("push while queue not drained");
  a_second_after_first: assert property (@(posedge clk) disable iff (rst)
    (push.fire && push.second_valid) |-> push.first_valid)
    else $error("second result without first");
  a_tail_advances: assert property (@(posedge clk) disable iff (rst)
    (pop && v1 && !push.fire) |=> (v0 && !v1))
    else $error("tail beat lost on pop");

endmodule

>>> rtl/greedy_word_wrap_line_breaker.sv
// Channel  Dir  Beat                                                   Accepted
// text     in   char_code, glyph_present, glyph_advance, end_of_text  valid && ready
// lines    out  is_line, line_char_count, line_pixel_width,          valid && ready
//               final_result
// apb      cfg  max_line_width @0x0, char_spacing @0x4                psel&penable&pwrite
//
// One character per cycle while the queue drains: input register, run arithmetic,
// two-slot result queue. A character gives zero, one or two result beats;
// the lines side takes one beat a cycle; a two-result character holds back the next.
// A text beat reaches lines through the input register and the queue head slot.
// rst is synchronous: runs cleared, max_line_width 320, char_spacing 0.
// A stall on lines holds the queue; text stays open while the queue can
// still take both results of the registered character.
module greedy_word_wrap_line_breaker (
  input  logic               clk,
  input  logic               rst,
  gwwlb_text_if.sink         text,
  gwwlb_line_if.source       lines,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  gwwlb_pkg::cfg_t   cfg;
  gwwlb_pkg::char_t  in_item;
  gwwlb_pkg::push_t  push;
  gwwlb_pkg::res_t   out_res;
  logic              slot_free;

  // register block
  gwwlb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_item.char_code     = text.char_code;
  assign in_item.glyph_present = text.glyph_present;
  assign in_item.glyph_advance = text.glyph_advance;
  assign in_item.end_of_text   = text.end_of_text;

  // line, whitespace and word runs; break decision
  gwwlb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .in_item   (in_item),
    .slot_free (slot_free),
    .push      (push)
  );

  // result beats wait here while lines is stalled
  gwwlb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .slot_free (slot_free),
    .out_valid (lines.valid),
    .out_ready (lines.ready),
    .out_res   (out_res)
  );

  assign lines.is_line          = out_res.is_line;
  assign lines.line_char_count  = out_res.line_char_count;
  assign lines.line_pixel_width = out_res.line_pixel_width;
  assign lines.final_result     = out_res.final_result;

endmodule
